/* rtl/core/knndg_pkg.sv */
// ---------------------------------------------------------------------------
// knndg_pkg: shared types and constants
// Widths, request and status codes, and the structs that connect the front
// end, the back end and the top level of the density-gradient normal block.
// ---------------------------------------------------------------------------
package knndg_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int PT_AW       = $clog2(MAX_POINTS);
    localparam int CNT_W       = PT_AW + 1;
    localparam int MAX_NB      = 32;
    localparam int NB_AW       = $clog2(MAX_NB);
    localparam int K_W         = NB_AW + 1;

    localparam int COORD_W     = 32;
    localparam int NRM_W       = 16;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 1;

    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 31;

    localparam logic [5:0]  NB_RESET  = 6'd10;
    localparam logic [15:0] OFS_RESET = 16'd6554;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_NB   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_OFS = 1'b1;

    // Request kinds as they arrive on the input stream.
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_APPEND = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [1:0] ST_FEW       = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_QUERY,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t                       op;
        logic [PT_AW-1:0]          index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } item_t;

    typedef struct packed {
        logic [5:0]  num_neighbours;
        logic [15:0] gradient_offset;
    } cfg_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [1:0]              status;
    } res_t;

endpackage

/* rtl/core/knndg_front.sv */
// ---------------------------------------------------------------------------
// knndg_front: request intake
// Accepts input transfers, decodes the request kind and holds the items in
// a two-entry queue in front of the back end.
// ---------------------------------------------------------------------------
module knndg_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [knndg_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                         s_tuser,
    output knndg_pkg::item_t                   q_item,
    output logic                               q_valid,
    input  logic                               q_ready
);
    import knndg_pkg::*;

    item_t      q_mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    item_t      in_item;
    logic       push;
    logic       pop;

    always_comb
    begin
        in_item.index = s_tdata[PT_AW-1:0];
        in_item.x     = s_tdata[PT_AW +: COORD_W];
        in_item.y     = s_tdata[PT_AW+COORD_W +: COORD_W];
        in_item.z     = s_tdata[PT_AW+2*COORD_W +: COORD_W];
        case (s_tuser)
            REQ_CLEAR:  in_item.op = OP_CLEAR;
            REQ_APPEND: in_item.op = OP_APPEND;
            REQ_QUERY:  in_item.op = OP_QUERY;
            default:    in_item.op = OP_NONE;
        endcase
    end

    assign s_tready = (fill_reg != 2'd2);
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = q_mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/core/knndg_sqrt.sv */
// ---------------------------------------------------------------------------
// knndg_sqrt: iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
module knndg_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);
    import knndg_pkg::*;

    logic [63:0] val_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    assign rem_sh = {rem_reg, val_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;
    assign done   = done_reg;
    assign root   = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                val_reg  <= value;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                val_reg  <= {val_reg[61:0], 2'b00};
                rem_reg  <= ge ? diff[33:0] : rem_sh[33:0];
                root_reg <= {root_reg[30:0], ge};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/knndg_div.sv */
// ---------------------------------------------------------------------------
// knndg_div: iterative restoring divider
// Divides a 62-bit dividend by a 32-bit divisor, one quotient bit per cycle.
// The caller guarantees that the quotient fits in 31 bits.
// ---------------------------------------------------------------------------
module knndg_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [61:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [30:0] quo
);
    import knndg_pkg::*;

    logic [31:0] rem_reg;
    logic [30:0] low_reg;
    logic [30:0] quo_reg;
    logic [31:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] cand;
    logic [32:0] diff;
    logic        ge;

    assign cand = {rem_reg, low_reg[30]};
    assign ge   = (cand >= {1'b0, den_reg});
    assign diff = cand - {1'b0, den_reg};
    assign done = done_reg;
    assign quo  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            low_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= {1'b0, num[61:31]};
                low_reg  <= num[30:0];
                den_reg  <= den;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= ge ? diff[31:0] : cand[31:0];
                low_reg  <= {low_reg[29:0], 1'b0};
                quo_reg  <= {quo_reg[29:0], ge};
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/core/knndg_back.sv */
// ---------------------------------------------------------------------------
// knndg_back: point store and normal engine
// Holds the point memory, runs the four k-nearest scans of a query, and
// turns the radii into a normalized density gradient.
// ---------------------------------------------------------------------------
module knndg_back (
    input  logic             clk,
    input  logic             rst_n,
    input  knndg_pkg::cfg_t  cfg,
    input  knndg_pkg::item_t q_item,
    input  logic             q_valid,
    output logic             q_ready,
    output logic             res_valid,
    input  logic             res_ready,
    output knndg_pkg::res_t  res
);
    import knndg_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_BASE_WAIT = 15'b000000000000010,
        S_SCAN      = 15'b000000000000100,
        S_SQRT_R    = 15'b000000000001000,
        S_MIN       = 15'b000000000010000,
        S_DIV_GO    = 15'b000000000100000,
        S_DIV_WAIT  = 15'b000000001000000,
        S_MUL1      = 15'b000000010000000,
        S_MUL2      = 15'b000000100000000,
        S_GSQ       = 15'b000001000000000,
        S_LSUM      = 15'b000010000000000,
        S_SQRT_L    = 15'b000100000000000,
        S_NDIV_GO   = 15'b001000000000000,
        S_NDIV_WAIT = 15'b010000000000000,
        S_DONE      = 15'b100000000000000
    } state_t;

    state_t state_reg;

    // Point memory, coordinates packed {z, y, x}.
    logic [3*COORD_W-1:0] mem [0:MAX_POINTS-1];
    logic [3*COORD_W-1:0] rd_data_reg;
    logic [PT_AW-1:0]     rd_addr;
    logic                 mem_we;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     issue_reg;
    logic signed [COORD_W-1:0] base_reg [0:2];
    logic [1:0]           pass_reg;
    logic [1:0]           sel_reg;

    // Distance pipeline.
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic [31:0]          abs_reg [0:2];
    logic [2:0]           sat2_reg;
    logic [63:0]          sq_reg  [0:2];
    logic [2:0]           sat3_reg;
    logic [63:0]          d2_reg;
    logic [33:0]          diff_c  [0:2];
    logic [33:0]          abs_c   [0:2];
    logic [65:0]          sum_c;

    // Sorted list of the nearest squared distances.
    logic [63:0]          best_reg  [0:MAX_NB-1];
    logic [MAX_NB-1:0]    bvalid_reg;
    logic [63:0]          best_next [0:MAX_NB-1];
    logic [MAX_NB-1:0]    bvalid_next;
    logic [MAX_NB-1:0]    gt;

    logic [K_W-1:0]       k;
    logic [K_W-1:0]       km1_full;
    logic [NB_AW-1:0]     km1;

    logic [31:0]          r_reg [0:3];
    logic [31:0]          m_reg;
    logic [31:0]          min01, min23, min_c;
    logic [30:0]          q_reg;
    logic [61:0]          prod_reg;
    logic [62:0]          prod2;
    logic [30:0]          t_reg [0:3];
    logic [31:0]          g_c   [0:2];
    logic [30:0]          gabs  [0:2];
    logic [61:0]          gsq_reg [0:2];
    logic [63:0]          len2_c;
    logic [31:0]          len_reg;
    logic signed [NRM_W-1:0] nrm_reg [0:2];
    logic [NRM_W-1:0]     c_ext;

    logic                 scan_done;
    logic                 issuing;
    logic                 out_free;
    logic                 res_load;
    res_t                 res_in;
    logic                 res_valid_reg;
    res_t                 res_reg;

    logic                 sq_start;
    logic [63:0]          sq_val;
    logic                 sq_done;
    logic [31:0]          sq_root;
    logic                 dv_start;
    logic [61:0]          dv_num;
    logic [31:0]          dv_den;
    logic                 dv_done;
    logic [30:0]          dv_quo;

    // Neighbour rank clamped into the supported range.
    always_comb
    begin
        if (K_W'(cfg.num_neighbours) < K_W'(2))
        begin
            k = K_W'(2);
        end
        else if (K_W'(cfg.num_neighbours) > K_W'(MAX_NB))
        begin
            k = K_W'(MAX_NB);
        end
        else
        begin
            k = K_W'(cfg.num_neighbours);
        end
        km1_full = k - K_W'(1);
        km1      = km1_full[NB_AW-1:0];
    end

    assign out_free  = !res_valid_reg || res_ready;
    assign q_ready   = (state_reg == S_IDLE) && out_free;
    assign issuing   = (state_reg == S_SCAN) && (issue_reg < count_reg);
    assign scan_done = (state_reg == S_SCAN) && (issue_reg == count_reg) &&
                       !v1_reg && !v2_reg && !v3_reg && !v4_reg;
    assign rd_addr   = (state_reg == S_SCAN) ? issue_reg[PT_AW-1:0] : q_item.index;
    assign mem_we    = q_valid && q_ready && (q_item.op == OP_APPEND) &&
                       (count_reg != CNT_W'(MAX_POINTS));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[PT_AW-1:0]] <= {q_item.z, q_item.y, q_item.x};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Offset position and per-axis absolute difference.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff_c[a] = 34'(signed'(rd_data_reg[a*COORD_W +: COORD_W]))
                      - 34'(base_reg[a])
                      - ((pass_reg == 2'(a + 1)) ? {18'b0, cfg.gradient_offset} : 34'd0);
            abs_c[a]  = diff_c[a][33] ? (34'd0 - diff_c[a]) : diff_c[a];
        end
        sum_c = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    end

    // Insertion into the sorted list; each entry takes its predecessor, the new distance or its own value.
    always_comb
    begin
        for (int i = 0; i < MAX_NB; i++)
        begin
            gt[i] = !bvalid_reg[i] || (best_reg[i] > d2_reg);
        end
        best_next[0]   = gt[0] ? d2_reg : best_reg[0];
        bvalid_next[0] = 1'b1;
        for (int i = 1; i < MAX_NB; i++)
        begin
            if (gt[i-1])
            begin
                best_next[i] = best_reg[i-1];
            end
            else if (gt[i])
            begin
                best_next[i] = d2_reg;
            end
            else
            begin
                best_next[i] = best_reg[i];
            end
            bvalid_next[i] = bvalid_reg[i] | bvalid_reg[i-1];
        end
    end

    // Smallest radius, gradient and its magnitudes.
    always_comb
    begin
        min01  = (r_reg[1] < r_reg[0]) ? r_reg[1] : r_reg[0];
        min23  = (r_reg[3] < r_reg[2]) ? r_reg[3] : r_reg[2];
        min_c  = (min23 < min01) ? min23 : min01;
        prod2  = 63'(prod_reg[61:30]) * 63'(q_reg);
        for (int a = 0; a < 3; a++)
        begin
            g_c[a]  = {1'b0, t_reg[0]} - {1'b0, t_reg[a+1]};
            gabs[a] = g_c[a][31] ? 31'(32'd0 - g_c[a]) : g_c[a][30:0];
        end
        len2_c = 64'(gsq_reg[0]) + 64'(gsq_reg[1]) + 64'(gsq_reg[2]);
        c_ext  = {1'b0, dv_quo[NRM_W-2:0]};
    end

    assign sq_start = scan_done || (state_reg == S_LSUM);
    assign sq_val   = (state_reg == S_SCAN) ? best_reg[km1] : len2_c;
    assign dv_start = ((state_reg == S_DIV_GO) && (m_reg != 32'd0)) ||
                      (state_reg == S_NDIV_GO);
    assign dv_num   = (state_reg == S_NDIV_GO)
                    ? (62'({gabs[sel_reg], 14'b0}) + 62'(len_reg[31:1]))
                    : {m_reg, 30'b0};
    assign dv_den   = (state_reg == S_NDIV_GO) ? len_reg : r_reg[sel_reg];

    knndg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_val),
        .done  (sq_done),
        .root  (sq_root)
    );

    knndg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dv_start),
        .num   (dv_num),
        .den   (dv_den),
        .done  (dv_done),
        .quo   (dv_quo)
    );

    // Result for a request that finishes straight from the queue, or for a finished query in S_DONE.
    always_comb
    begin
        res_load        = 1'b0;
        res_in.normal_x = '0;
        res_in.normal_y = '0;
        res_in.normal_z = '0;
        res_in.status   = ST_OK;
        if (state_reg == S_DONE)
        begin
            res_load        = out_free;
            res_in.normal_x = nrm_reg[0];
            res_in.normal_y = nrm_reg[1];
            res_in.normal_z = nrm_reg[2];
        end
        else if (q_valid && q_ready)
        begin
            case (q_item.op)
                OP_APPEND:
                begin
                    res_load = 1'b1;
                    if (count_reg == CNT_W'(MAX_POINTS))
                    begin
                        res_in.status = ST_FULL;
                    end
                end
                OP_QUERY:
                begin
                    if (CNT_W'(q_item.index) >= count_reg)
                    begin
                        res_load      = 1'b1;
                        res_in.status = ST_BAD_INDEX;
                    end
                    else if (count_reg < CNT_W'(k))
                    begin
                        res_load      = 1'b1;
                        res_in.status = ST_FEW;
                    end
                end
                default:
                begin
                    res_load = 1'b1;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            pass_reg      <= '0;
            sel_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            bvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            m_reg         <= '0;
            q_reg         <= '0;
            prod_reg      <= '0;
            len_reg       <= '0;
            sat2_reg      <= '0;
            sat3_reg      <= '0;
            d2_reg        <= '0;
            for (int a = 0; a < 3; a++)
            begin
                base_reg[a] <= '0;
                abs_reg[a]  <= '0;
                sq_reg[a]   <= '0;
                gsq_reg[a]  <= '0;
                nrm_reg[a]  <= '0;
            end
            for (int a = 0; a < 4; a++)
            begin
                r_reg[a] <= '0;
                t_reg[a] <= '0;
            end
            for (int i = 0; i < MAX_NB; i++)
            begin
                best_reg[i] <= '0;
            end
        end
        else
        begin
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
                res_reg       <= res_in;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end

            // Distance pipeline runs freely behind the issue counter.
            v1_reg <= issuing;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            for (int a = 0; a < 3; a++)
            begin
                abs_reg[a]  <= abs_c[a][31:0];
                sat2_reg[a] <= |abs_c[a][33:32];
                sq_reg[a]   <= 64'(abs_reg[a]) * 64'(abs_reg[a]);
            end
            sat3_reg <= sat2_reg;
            d2_reg   <= ((|sat3_reg) || (|sum_c[65:64])) ? '1 : sum_c[63:0];
            if (v4_reg)
            begin
                best_reg   <= best_next;
                bvalid_reg <= bvalid_next;
            end
            if (issuing)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        case (q_item.op)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            OP_APPEND:
                            begin
                                if (mem_we)
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_QUERY:
                            begin
                                if (!res_load)
                                begin
                                    pass_reg  <= '0;
                                    state_reg <= S_BASE_WAIT;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_BASE_WAIT:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        base_reg[a] <= rd_data_reg[a*COORD_W +: COORD_W];
                    end
                    issue_reg  <= '0;
                    bvalid_reg <= '0;
                    state_reg  <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_done)
                    begin
                        state_reg <= S_SQRT_R;
                    end
                end
                S_SQRT_R:
                begin
                    if (sq_done)
                    begin
                        r_reg[pass_reg] <= sq_root;
                        if (pass_reg == 2'd3)
                        begin
                            state_reg <= S_MIN;
                        end
                        else
                        begin
                            pass_reg   <= pass_reg + 2'd1;
                            issue_reg  <= '0;
                            bvalid_reg <= '0;
                            state_reg  <= S_SCAN;
                        end
                    end
                end
                S_MIN:
                begin
                    m_reg     <= min_c;
                    sel_reg   <= '0;
                    state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    if (m_reg == 32'd0)
                    begin
                        // Zero radius: only other zero radii share the
                        // saturated density.
                        t_reg[sel_reg] <= (r_reg[sel_reg] == 32'd0) ? Q30_ONE : 31'd0;
                        if (sel_reg == 2'd3)
                        begin
                            state_reg <= S_GSQ;
                        end
                        else
                        begin
                            sel_reg <= sel_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT:
                begin
                    if (dv_done)
                    begin
                        q_reg     <= dv_quo;
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    prod_reg  <= 62'(q_reg) * 62'(q_reg);
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    t_reg[sel_reg] <= prod2[60:30];
                    if (sel_reg == 2'd3)
                    begin
                        state_reg <= S_GSQ;
                    end
                    else
                    begin
                        sel_reg   <= sel_reg + 2'd1;
                        state_reg <= S_DIV_GO;
                    end
                end
                S_GSQ:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        gsq_reg[a] <= 62'(gabs[a]) * 62'(gabs[a]);
                    end
                    state_reg <= S_LSUM;
                end
                S_LSUM:
                begin
                    state_reg <= S_SQRT_L;
                end
                S_SQRT_L:
                begin
                    if (sq_done)
                    begin
                        len_reg <= sq_root;
                        sel_reg <= '0;
                        if (sq_root == 32'd0)
                        begin
                            for (int a = 0; a < 3; a++)
                            begin
                                nrm_reg[a] <= '0;
                            end
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_NDIV_GO;
                        end
                    end
                end
                S_NDIV_GO:
                begin
                    state_reg <= S_NDIV_WAIT;
                end
                S_NDIV_WAIT:
                begin
                    if (dv_done)
                    begin
                        nrm_reg[sel_reg] <= g_c[sel_reg][31] ? (NRM_W'(0) - c_ext) : c_ext;
                        if (sel_reg == 2'd2)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            sel_reg   <= sel_reg + 2'd1;
                            state_reg <= S_NDIV_GO;
                        end
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/knn_density_gradient_normal.sv */
// ---------------------------------------------------------------------------
// knn_density_gradient_normal: point normals from a k-nearest density gradient
// Stores 3D points and answers normal queries from the gradient of a
// k-nearest-neighbour density estimate.
// ---------------------------------------------------------------------------
//
//   Channel    Direction  Handshake            Payload
//   s_*        in         s_tvalid/s_tready    tuser req_type, tdata index+coords
//   m_*        out        m_tvalid/m_tready    tdata normals and status
//   cfg_*      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A clear, append or unused request is answered through the intake queue and
// then the back end's output register. A query holds the back end for four
// brute-force scans of the N stored points at one memory read per cycle,
// followed by the shared iterative square root and divide.
// Reset (rst_n low) empties the store and loads the default registers.
// The intake queue keeps accepting transfers while a result waits on m_*, until it is full.
// ---------------------------------------------------------------------------
module knn_density_gradient_normal (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0: point_index[9:0], coord_x, coord_y, coord_z, zero pad.
    input  logic [knndg_pkg::IN_TDATA_W-1:0]    s_tdata,
    // tuser: req_type.
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // tdata from bit 0: normal_x, normal_y, normal_z, status[1:0], zero pad.
    output logic [knndg_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [knndg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);
    import knndg_pkg::*;

    cfg_t  cfg_reg;
    item_t q_item;
    logic  q_valid;
    logic  q_ready;
    res_t  res;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_neighbours  <= NB_RESET;
            cfg_reg.gradient_offset <= OFS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_NUM_NB:
                begin
                    cfg_reg.num_neighbours <= cfg_data[5:0];
                end
                default:
                begin
                    cfg_reg.gradient_offset <= cfg_data;
                end
            endcase
        end
    end

    // Front end: accepts and decodes requests into a short queue.
    knndg_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_item   (q_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    // Back end: point store, scans and normal arithmetic, with its own output
    // register; a stalled sink stops it taking items, and the intake queue then fills and stalls.
    knndg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_item    (q_item),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {6'b0, res.status, res.normal_z, res.normal_y, res.normal_x};

endmodule

/* tb/tb_knn_density_gradient_normal.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_knn_density_gradient_normal: self-checking regression
// Drives clear, append, query and unused requests and register writes into the
// block with random gaps on both streams. A scoreboard keeps its own copy
// of the point store and the registers, predicts each result and compares it
// field by field.

class normal_scoreboard;

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [1:0]  status;
    } normal_result_t;

    logic signed [31:0] pts [1024][3];
    int unsigned        npts;
    logic [5:0]         k_reg;
    logic [15:0]        step_reg;
    normal_result_t     expected_q [$];
    int                 fails;

    function void clear_state();
        npts       = 0;
        k_reg      = knndg_pkg::NB_RESET;
        step_reg   = knndg_pkg::OFS_RESET;
        fails      = 0;
        expected_q = {};
    endfunction

    function void write_reg(logic [knndg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        if (idx == knndg_pkg::CFG_NUM_NB)
            k_reg = val[5:0];
        else
            step_reg = val;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned probe;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= res + probe)
            begin
                v   = v - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Per-axis square; a difference of 2^32 or more saturates the distance.
    function longint unsigned axis_sq(longint d);
        longint unsigned a;
        a = (d < 0) ? -d : d;
        if (a >= 64'h1_0000_0000)
            return '1;
        return a * a;
    endfunction

    function longint unsigned sat_add(longint unsigned a, longint unsigned b);
        return (a > ~b) ? '1 : a + b;
    endfunction

    // Radius to the k-th nearest stored point, by an insertion-sorted list.
    function longint unsigned kth_radius(longint p0, longint p1, longint p2, int unsigned k);
        longint unsigned best [32];
        longint unsigned d2;
        int unsigned     n;
        int unsigned     pos;
        n = 0;
        for (int unsigned j = 0; j < npts; j++)
        begin
            d2 = sat_add(sat_add(axis_sq(longint'(pts[j][0]) - p0),
                                 axis_sq(longint'(pts[j][1]) - p1)),
                         axis_sq(longint'(pts[j][2]) - p2));
            if (n == k && d2 >= best[k-1])
                continue;
            if (n < k)
                n++;
            pos = n - 1;
            while (pos > 0 && best[pos-1] > d2)
            begin
                best[pos] = best[pos-1];
                pos--;
            end
            best[pos] = d2;
        end
        return isqrt(best[k-1]);
    endfunction

    // Density scaled by m^3, in Q30.
    function longint scaled_density(longint unsigned m, longint unsigned r);
        longint unsigned q;
        if (m == 0)
            return (r == 0) ? (64'd1 << 30) : 0;
        q = (m << 30) / r;
        return longint'((((q * q) >> 30) * q) >> 30);
    endfunction

    function logic [15:0] unit_comp(longint g, longint unsigned len);
        longint unsigned a;
        longint unsigned c;
        a = (g < 0) ? -g : g;
        c = (a * 16384 + len / 2) / len;
        return (g < 0) ? -c[15:0] : c[15:0];
    endfunction

    function void note_input(knndg_pkg::op_t op, logic [9:0] idx,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        normal_result_t  res;
        int unsigned     k;
        longint          base [3];
        longint unsigned r [4];
        longint unsigned m;
        longint unsigned len2;
        longint unsigned len;
        longint          t0;
        longint          g [3];
        res = '{16'd0, 16'd0, 16'd0, knndg_pkg::ST_OK};
        case (op)
            knndg_pkg::OP_CLEAR:
                npts = 0;
            knndg_pkg::OP_APPEND:
                if (npts >= 1024)
                    res.status = knndg_pkg::ST_FULL;
                else
                begin
                    pts[npts][0] = x;
                    pts[npts][1] = y;
                    pts[npts][2] = z;
                    npts++;
                end
            knndg_pkg::OP_QUERY:
            begin
                k = (k_reg < 2) ? 2 : (k_reg > 32) ? 32 : k_reg;
                if (idx >= npts)
                    res.status = knndg_pkg::ST_BAD_INDEX;
                else if (npts < k)
                    res.status = knndg_pkg::ST_FEW;
                else
                begin
                    for (int a = 0; a < 3; a++)
                        base[a] = pts[idx][a];
                    r[0] = kth_radius(base[0], base[1], base[2], k);
                    r[1] = kth_radius(base[0] + step_reg, base[1], base[2], k);
                    r[2] = kth_radius(base[0], base[1] + step_reg, base[2], k);
                    r[3] = kth_radius(base[0], base[1], base[2] + step_reg, k);
                    m = r[0];
                    for (int a = 1; a < 4; a++)
                        if (r[a] < m)
                            m = r[a];
                    t0   = scaled_density(m, r[0]);
                    len2 = 0;
                    for (int a = 0; a < 3; a++)
                    begin
                        g[a] = t0 - scaled_density(m, r[a+1]);
                        len2 += longint'(g[a] * g[a]);
                    end
                    len = isqrt(len2);
                    if (len != 0)
                    begin
                        res.nx = unit_comp(g[0], len);
                        res.ny = unit_comp(g[1], len);
                        res.nz = unit_comp(g[2], len);
                    end
                end
            end
            default: ;
        endcase
        expected_q.push_back(res);
    endfunction

    function void check_result(logic [knndg_pkg::OUT_TDATA_W-1:0] d);
        normal_result_t exp_r;
        if (expected_q.size() == 0)
        begin
            fails++;
            if (fails <= 10)
                $display("ERROR: unexpected result %h", d);
            return;
        end
        exp_r = expected_q.pop_front();
        if (d[15:0] !== exp_r.nx || d[31:16] !== exp_r.ny || d[47:32] !== exp_r.nz ||
            d[49:48] !== exp_r.status)
        begin
            fails++;
            if (fails <= 10)
                $display("ERROR: normal (%h %h %h) status %0d, expected (%h %h %h) status %0d",
                         d[15:0], d[31:16], d[47:32], d[49:48],
                         exp_r.nx, exp_r.ny, exp_r.nz, exp_r.status);
        end
    endfunction

endclass

module tb_knn_density_gradient_normal;

    import knndg_pkg::*;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // tdata from bit 0: point_index[9:0], coord_x, coord_y, coord_z, zero pad.
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    // tuser: req_type.
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // tdata from bit 0: normal_x, normal_y, normal_z, status[1:0], zero pad.
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [15:0]            cfg_data  = '0;

    normal_scoreboard sb;
    // When set, neither stream idles, so back-to-back transfers occur.
    bit               no_idle;
    // Cycles the result side holds off at its next turn.
    int               rx_hold;
    int               rand_items;
    longint           cycles;

    always #2 clk = ~clk;

    knn_density_gradient_normal i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // One request transfer. The valid is lowered only when a gap follows, so
    // back-to-back items never see a low and a high in the same step.
    task automatic send_req(op_t op, logic [9:0] idx,
                            logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, z, y, x, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_input(op, idx, x, y, z);
    endtask

    // Wait until every expected result has come back, with the input idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One register write; the valid drops between it and the next write.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [31:0] near(logic [31:0] c);
        return c + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    // Result side: a random stall per transfer, plus a long hold on request.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (rx_hold > 0)
            begin
                gap     = gap + rx_hold;
                rx_hold = 0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);

    // Watchdog: ends the run with a fail once the cycle counter passes its limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("knn_density_gradient_normal regression: fail");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] bx, by, bz;
        logic [9:0]  qidx;
        int          n;
        sb = new();
        sb.clear_state();
        cycles  = 0;
        rx_hold = 0;
        no_idle = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-store query, the unused request, too few points.
        send_req(OP_QUERY, 10'd0, 32'd0, 32'd0, 32'd0);
        send_req(OP_NONE, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(OP_CLEAR, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(OP_APPEND, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_req(OP_APPEND, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_req(OP_QUERY, 10'd0, 32'd0, 32'd0, 32'd0);
        send_req(OP_QUERY, 10'h3FF, 32'd0, 32'd0, 32'd0);
        drain();

        // Smallest k and largest step: distances between the extreme points
        // saturate.
        write_cfg(CFG_NUM_NB, 16'd2);
        write_cfg(CFG_GRAD_OFS, 16'hFFFF);
        send_req(OP_QUERY, 10'd0, 32'd0, 32'd0, 32'd0);
        send_req(OP_QUERY, 10'd1, 32'd0, 32'd0, 32'd0);
        // Two coincident points give a zero radius at the point itself.
        send_req(OP_CLEAR, 10'd0, 32'd0, 32'd0, 32'd0);
        send_req(OP_APPEND, 10'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_req(OP_APPEND, 10'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        send_req(OP_APPEND, 10'd0, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000);
        send_req(OP_QUERY, 10'd0, 32'd0, 32'd0, 32'd0);
        send_req(OP_QUERY, 10'd2, 32'd0, 32'd0, 32'd0);
        drain();

        // A zero step leaves all four densities equal: zero gradient.
        write_cfg(CFG_GRAD_OFS, 16'd0);
        send_req(OP_QUERY, 10'd2, 32'd0, 32'd0, 32'd0);
        drain();

        // Largest rank with exactly as many points as neighbours, back to back.
        write_cfg(CFG_NUM_NB, 16'd32);
        write_cfg(CFG_GRAD_OFS, 16'd1);
        no_idle = 1'b1;
        send_req(OP_CLEAR, 10'd0, 32'd0, 32'd0, 32'd0);
        for (int i = 0; i < 32; i++)
            send_req(OP_APPEND, 10'd0, $urandom_range(0, 32'h00FF_FFFF),
                     $urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF));
        no_idle = 1'b0;
        send_req(OP_QUERY, 10'd31, 32'd0, 32'd0, 32'd0);
        send_req(OP_QUERY, 10'h3FF, 32'd0, 32'd0, 32'd0);
        drain();

        // Back pressure: results are held off while appends keep coming, so
        // the intake fills and stalls.
        write_cfg(CFG_NUM_NB, 16'd10);
        write_cfg(CFG_GRAD_OFS, 16'd6554);
        rx_hold = 1500;
        no_idle = 1'b1;
        send_req(OP_CLEAR, 10'd0, 32'd0, 32'd0, 32'd0);
        bx = $urandom_range(0, 32'h0FFF_FFFF);
        by = $urandom_range(0, 32'h0FFF_FFFF);
        bz = $urandom_range(0, 32'h0FFF_FFFF);
        for (int i = 0; i < 40; i++)
            send_req(OP_APPEND, 10'd0, near(bx), near(by), near(bz));
        send_req(OP_QUERY, 10'($urandom_range(0, 39)), 32'd0, 32'd0, 32'd0);
        no_idle = 1'b0;
        drain();

        // Random part: mostly point sets followed by queries, some noise.
        rand_items = 0;
        while (rand_items < 50)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                drain();
                case ($urandom_range(0, 4))
                    0: write_cfg(CFG_NUM_NB, 16'd2);
                    1: write_cfg(CFG_NUM_NB, 16'($urandom_range(0, 63)));
                    default: write_cfg(CFG_NUM_NB, 16'($urandom_range(2, 12)));
                endcase
                case ($urandom_range(0, 3))
                    0: write_cfg(CFG_GRAD_OFS, 16'hFFFF);
                    1: write_cfg(CFG_GRAD_OFS, 16'd1);
                    default: write_cfg(CFG_GRAD_OFS, 16'($urandom_range(1, 65535)));
                endcase
            end
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    op_t op;
                    op = op_t'($urandom_range(0, 3));
                    send_req(op, 10'($urandom), $urandom, $urandom, $urandom);
                    if (op != OP_NONE)
                        rand_items++;
                end
            end
            else
            begin
                send_req(OP_CLEAR, 10'($urandom), $urandom, $urandom, $urandom);
                n  = $urandom_range(1, 24);
                bx = $urandom;
                by = $urandom;
                bz = $urandom;
                for (int i = 0; i < n; i++)
                    send_req(OP_APPEND, 10'($urandom), near(bx), near(by), near(bz));
                for (int i = 0; i < 3; i++)
                begin
                    qidx = ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                                       : 10'($urandom_range(0, n - 1));
                    send_req(OP_QUERY, qidx, $urandom, $urandom, $urandom);
                end
                rand_items += n + 4;
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (50) @(posedge clk);
        if (sb.fails == 0 && sb.expected_q.size() == 0)
            $display("knn_density_gradient_normal regression: pass");
        else
            $display("knn_density_gradient_normal regression: fail");
        $finish;
    end

endmodule
